### hdl/pdm_saw_oscillator_bank_top_assert.svh
// ----------------------------------------------------------------------------
// pdm_saw_oscillator_bank_top_assert.svh
// assertion macros shared by the oscillator bank modules
// ----------------------------------------------------------------------------
`ifndef PDM_SAW_OSCILLATOR_BANK_TOP_ASSERT_SVH
`define PDM_SAW_OSCILLATOR_BANK_TOP_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define PDMSAW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdmsaw next-cycle check failed");

// consequent must hold in the same cycle as the antecedent
`define PDMSAW_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdmsaw same-cycle check failed");

`endif

### hdl/pdmsaw_pkg.sv
// ----------------------------------------------------------------------------
// pdmsaw_pkg
// types, constants and the octave shift table of the oscillator bank
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdmsaw_pkg;

  localparam int NUM_OSC      = 6;
  localparam int MAX_OSC      = 6;
  localparam int PERIOD_WIDTH = 24;
  localparam int ERR_WIDTH    = PERIOD_WIDTH + 2;

  localparam int BASE_W  = 20;
  localparam int STEP_W  = 10;
  localparam int KNOB_W  = 12;
  localparam int OUT_W   = 6;
  localparam int ROW_W   = 4;
  localparam int NUM_ROW = 16;
  localparam int SHIFT_MAX = 3;

  // base plus five sums of two steps
  localparam int RAW_W   = BASE_W + 1;
  localparam int SHL_W   = RAW_W + SHIFT_MAX;
  localparam int CALC_W  = (SHL_W > PERIOD_WIDTH) ? SHL_W : PERIOD_WIDTH + 1;

  localparam int RST_PERIOD_BASE = 22000;
  localparam int RST_PERIOD_STEP = 10;

  // oscillators below this index shift left, the rest shift right
  localparam int NUM_SHL = 3;

  typedef logic [PERIOD_WIDTH-1:0] period_t;
  typedef logic [ERR_WIDTH-1:0]    err_t;
  typedef logic [NUM_OSC-1:0][PERIOD_WIDTH-1:0] period_vec_t;

  typedef struct packed {
    logic              load;
    logic [BASE_W-1:0] base_period;
    logic [STEP_W-1:0] detune_step;
    logic [STEP_W-1:0] spread_step;
    logic [KNOB_W-1:0] octave_knob;
  } ctrl_t;

  localparam logic [1:0] OCT_ROWS [NUM_ROW][MAX_OSC] = '{
    '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
    '{2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0},
    '{2'd2, 2'd1, 2'd0, 2'd0, 2'd0, 2'd0},
    '{2'd3, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0},
    '{2'd3, 2'd2, 2'd1, 2'd0, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0, 2'd1, 2'd2},
    '{2'd3, 2'd2, 2'd1, 2'd1, 2'd2, 2'd3},
    '{2'd2, 2'd2, 2'd0, 2'd0, 2'd2, 2'd2},
    '{2'd2, 2'd1, 2'd0, 2'd0, 2'd1, 2'd2},
    '{2'd2, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1},
    '{2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd2},
    '{2'd0, 2'd0, 2'd0, 2'd0, 2'd2, 2'd2},
    '{2'd0, 2'd0, 2'd0, 2'd0, 2'd2, 2'd3},
    '{2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd2},
    '{2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1}
  };

endpackage

### hdl/pdmsaw_period.sv
// ----------------------------------------------------------------------------
// pdmsaw_period
// period registers of all oscillators, rebuilt on a control transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pdm_saw_oscillator_bank_top_assert.svh"

module pdmsaw_period (
  input  logic                 clk,
  input  logic                 rst,
  input  pdmsaw_pkg::ctrl_t    ctrl,
  output pdmsaw_pkg::period_vec_t periods
);
  import pdmsaw_pkg::*;

  logic [ROW_W-1:0] row;
  period_vec_t      period;
  period_vec_t      period_next;

  assign row = ctrl.octave_knob[KNOB_W-1 -: ROW_W];

  for (genvar k = 0; k < NUM_OSC; k++) begin : g_osc
    logic [RAW_W-1:0]  step;
    logic [RAW_W-1:0]  raw;
    logic [1:0]        sh;
    logic [CALC_W-1:0] shifted;

    assign step = RAW_W'(ctrl.detune_step) + RAW_W'(ctrl.spread_step);
    assign raw  = RAW_W'(ctrl.base_period) + RAW_W'(k) * step;
    assign sh   = OCT_ROWS[row][k];

    always_comb begin
      if (k < NUM_SHL) begin
        shifted = CALC_W'(raw) << sh;
      end else begin
        shifted = CALC_W'(raw) >> sh;
      end
      // saturate at the largest period value
      if (shifted > CALC_W'({PERIOD_WIDTH{1'b1}})) begin
        period_next[k] = {PERIOD_WIDTH{1'b1}};
      end else begin
        period_next[k] = shifted[PERIOD_WIDTH-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        period[k] <= PERIOD_WIDTH'(RST_PERIOD_BASE + RST_PERIOD_STEP * k);
      end else if (ctrl.load) begin
        period[k] <= period_next[k];
      end
    end
  end

  assign periods = period;

  `PDMSAW_ASSERT_NEXT(a_period_hold, !ctrl.load, $stable(period))

endmodule

### hdl/pdmsaw_osc.sv
// ----------------------------------------------------------------------------
// pdmsaw_osc
// one sawtooth oscillator with first-order sigma-delta pulse output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pdm_saw_oscillator_bank_top_assert.svh"

module pdmsaw_osc (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick,
  input  pdmsaw_pkg::period_t period,
  output logic                pulse
);
  import pdmsaw_pkg::*;

  period_t phase;
  err_t    err;
  period_t phase_next;
  err_t    err_next;
  period_t phase_wrap;

  always_comb begin
    phase_wrap = (phase >= period) ? '0 : phase;
    phase_next = phase_wrap + PERIOD_WIDTH'(1);
    pulse      = $signed({2'b00, phase_next}) >= $signed(err);
    err_next   = (pulse ? {2'b00, period} : '0) - {2'b00, phase_next} + err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      err   <= '0;
    end else if (tick) begin
      phase <= phase_next;
      err   <= err_next;
    end
  end

  // phase is at most the period after a wrap, so the increment never rolls over
  `PDMSAW_ASSERT_NEXT(a_phase_nonzero, tick, phase != '0)

endmodule

### hdl/pdm_saw_oscillator_bank_top.sv
// ----------------------------------------------------------------------------
// pdm_saw_oscillator_bank_top
// bank of sawtooth oscillators with pulse-density outputs
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready) carries one item per transfer. kind 0
//   is a sample tick: every oscillator steps once and one result is produced.
//   kind 1 is a control update: periods are rebuilt from base_period,
//   detune_step, spread_step and octave_knob; no result is produced.
//   Output channel (out_valid / out_ready) carries osc_bits, one bit per
//   oscillator.
//   A tick waits in the input register, and its result is held in the
//   result register. Throughput: one item per clock unless a tick stalls;
//   the input register and the result register each hold one item.
//   Stall: while the result register is full and out_ready is low, a waiting
//   tick holds in the input register and in_ready drops; control items still
//   pass since they give no result.
//   Reset: rst clears both channels, sets phases and error accumulators to
//   zero and periods to 22000 + 10 * k. Items are taken right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pdm_saw_oscillator_bank_top_assert.svh"

module pdm_saw_oscillator_bank_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic [pdmsaw_pkg::BASE_W-1:0]     base_period,
  input  logic [pdmsaw_pkg::STEP_W-1:0]     detune_step,
  input  logic [pdmsaw_pkg::STEP_W-1:0]     spread_step,
  input  logic [pdmsaw_pkg::KNOB_W-1:0]     octave_knob,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pdmsaw_pkg::OUT_W-1:0]      osc_bits
);
  import pdmsaw_pkg::*;

  logic              in_full;
  logic              kind_q;
  logic [BASE_W-1:0] base_q;
  logic [STEP_W-1:0] detune_q;
  logic [STEP_W-1:0] spread_q;
  logic [KNOB_W-1:0] knob_q;

  logic              advance;
  logic              tick;
  ctrl_t             ctrl;
  period_vec_t       periods;
  logic [NUM_OSC-1:0] pulses;

  // control items never wait on the output side
  assign advance  = in_full && (kind_q || !out_valid || out_ready);
  assign in_ready = !in_full || advance;
  assign tick     = advance && !kind_q;

  assign ctrl.load        = advance && kind_q;
  assign ctrl.base_period = base_q;
  assign ctrl.detune_step = detune_q;
  assign ctrl.spread_step = spread_q;
  assign ctrl.octave_knob = knob_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      kind_q   <= kind;
      base_q   <= base_period;
      detune_q <= detune_step;
      spread_q <= spread_step;
      knob_q   <= octave_knob;
    end
  end

  pdmsaw_period u_period (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .periods (periods)
  );

  for (genvar k = 0; k < NUM_OSC; k++) begin : g_osc
    pdmsaw_osc u_osc (
      .clk    (clk),
      .rst    (rst),
      .tick   (tick),
      .period (periods[k]),
      .pulse  (pulses[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      osc_bits <= OUT_W'(pulses);
    end
  end

  `PDMSAW_ASSERT_NEXT(a_tick_gives_result, tick, out_valid)
  `PDMSAW_ASSERT_NEXT(a_ctrl_no_result, ctrl.load && !out_valid, !out_valid)
  `PDMSAW_ASSERT_SAME(a_stall_only_on_full, in_full && !in_ready,
                      !kind_q && out_valid && !out_ready)

endmodule
